>>> hw/rtl/lttc_pkg.sv
package lttc_pkg;

    // Default geometry of the tag store.
    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_COORD_BITS = 12;

    // Capacity register.
    localparam int            CAP_BITS  = 5;
    localparam logic [4:0]    CAP_RESET = 5'd16;

    // Operation codes carried by an input word.
    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_FLUSH  = 1'b1
    } op_t;

    // Outcome of one lookup, passed from the replacement logic to the top level.
    typedef struct packed {
        logic hit;
        logic fill;
        logic evict;
    } lttc_decision_t;

endpackage

>>> hw/rtl/lru_tile_tag_cache_unit.sv
// Channel   Signals                                           Word accepted when
// input     in_valid, in_stall, operation, tile_x, tile_y     in_valid && !in_stall
// output    out_valid, out_stall, hit, slot, evicted,         out_valid && !out_stall
//           evicted_x, evicted_y
// config    cfg_write, cfg_data                               cfg_write
//
// One word per cycle while the output is not stalled; an accepted input word passes
// through the input register and then the result register to the output.
// The tag compare, replacement choice and state update all happen in the cycle
// the word leaves the input register, so each word sees the state left by the last.
// Reset clears all entries at once and sets the capacity to 16.
// A stalled output word holds the input register, which then stalls the input.
module lru_tile_tag_cache_unit #(
    parameter int ENTRIES    = lttc_pkg::DEF_ENTRIES,
    parameter int COORD_BITS = lttc_pkg::DEF_COORD_BITS,
    parameter int SLOT_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic [COORD_BITS-1:0]         tile_x,
    input  logic [COORD_BITS-1:0]         tile_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic [SLOT_BITS-1:0]          slot,
    output logic                          evicted,
    output logic [COORD_BITS-1:0]         evicted_x,
    output logic [COORD_BITS-1:0]         evicted_y,
    input  logic                          cfg_write,
    input  logic [lttc_pkg::CAP_BITS-1:0] cfg_data
);
    import lttc_pkg::*;

    logic                  in_valid_reg;
    op_t                   operation_reg;
    logic [COORD_BITS-1:0] tile_x_reg;
    logic [COORD_BITS-1:0] tile_y_reg;
    logic [CAP_BITS-1:0]   capacity_reg;

    logic                  out_valid_reg;
    logic                  hit_reg;
    logic [SLOT_BITS-1:0]  slot_reg;
    logic                  evicted_reg;
    logic [COORD_BITS-1:0] evicted_x_reg;
    logic [COORD_BITS-1:0] evicted_y_reg;

    logic                  advance;
    logic                  accept;
    logic                  flush;
    logic [ENTRIES-1:0]    match_vec;
    logic [ENTRIES-1:0]    slot_sel;
    logic [ENTRIES-1:0]    write_sel;
    logic [COORD_BITS-1:0] victim_x;
    logic [COORD_BITS-1:0] victim_y;
    logic [SLOT_BITS-1:0]  slot_idx;
    lttc_decision_t        decision;

    // Handshake: the input register moves on unless the output word is stalled.
    assign advance  = in_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign flush    = (operation_reg == OP_FLUSH);

    // Capacity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_write)
        begin
            capacity_reg <= cfg_data;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            operation_reg <= op_t'(operation);
            tile_x_reg    <= tile_x;
            tile_y_reg    <= tile_y;
        end
    end

    // Tag storage and compare.
    lttc_tags #(
        .ENTRIES    (ENTRIES),
        .COORD_BITS (COORD_BITS)
    ) u_tags (
        .clk        (clk),
        .tile_x     (tile_x_reg),
        .tile_y     (tile_y_reg),
        .write_sel  (write_sel),
        .victim_sel (slot_sel),
        .match_vec  (match_vec),
        .victim_x   (victim_x),
        .victim_y   (victim_y)
    );

    // Recency tracking and replacement choice.
    lttc_repl #(
        .ENTRIES (ENTRIES)
    ) u_repl (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .flush     (flush),
        .match_vec (match_vec),
        .capacity  (capacity_reg),
        .decision  (decision),
        .slot_sel  (slot_sel)
    );

    // Tags are written on a fill or an eviction.
    assign write_sel = (advance && (decision.fill || decision.evict)) ? slot_sel : '0;

    // Encode the one-hot slot.
    always_comb
    begin
        slot_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (slot_sel[i])
            begin
                slot_idx = slot_idx | SLOT_BITS'(i);
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hit_reg       <= decision.hit;
            slot_reg      <= slot_idx;
            evicted_reg   <= decision.evict;
            evicted_x_reg <= decision.evict ? victim_x : '0;
            evicted_y_reg <= decision.evict ? victim_y : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign slot      = slot_reg;
    assign evicted   = evicted_reg;
    assign evicted_x = evicted_x_reg;
    assign evicted_y = evicted_y_reg;

endmodule

>>> hw/rtl/lttc_tags.sv
module lttc_tags #(
    parameter int ENTRIES    = lttc_pkg::DEF_ENTRIES,
    parameter int COORD_BITS = lttc_pkg::DEF_COORD_BITS
) (
    input  logic                  clk,
    input  logic [COORD_BITS-1:0] tile_x,
    input  logic [COORD_BITS-1:0] tile_y,
    input  logic [ENTRIES-1:0]    write_sel,
    input  logic [ENTRIES-1:0]    victim_sel,
    output logic [ENTRIES-1:0]    match_vec,
    output logic [COORD_BITS-1:0] victim_x,
    output logic [COORD_BITS-1:0] victim_y
);
    import lttc_pkg::*;

    logic [COORD_BITS-1:0] col_reg [ENTRIES];
    logic [COORD_BITS-1:0] row_reg [ENTRIES];

    // Install the requested coordinates in the selected entry.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (write_sel[i])
            begin
                col_reg[i] <= tile_x;
                row_reg[i] <= tile_y;
            end
        end
    end

    // Compare every entry against the request in parallel.
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_vec[i] = (col_reg[i] == tile_x) && (row_reg[i] == tile_y);
        end
    end

    // Read out the coordinates of the one-hot selected victim.
    always_comb
    begin
        victim_x = '0;
        victim_y = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (victim_sel[i])
            begin
                victim_x = victim_x | col_reg[i];
                victim_y = victim_y | row_reg[i];
            end
        end
    end

endmodule

>>> hw/rtl/lttc_repl.sv
module lttc_repl #(
    parameter int ENTRIES = lttc_pkg::DEF_ENTRIES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           fire,
    input  logic                           flush,
    input  logic [ENTRIES-1:0]             match_vec,
    input  logic [lttc_pkg::CAP_BITS-1:0]  capacity,
    output lttc_pkg::lttc_decision_t       decision,
    output logic [ENTRIES-1:0]             slot_sel
);
    import lttc_pkg::*;

    localparam int RANK_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FILL_BITS = $clog2(ENTRIES + 1);
    localparam int CMP_BITS  = (FILL_BITS > CAP_BITS) ? FILL_BITS : CAP_BITS;

    logic [ENTRIES-1:0]   valid_reg;
    logic [RANK_BITS-1:0] rank_reg [ENTRIES];
    logic [FILL_BITS-1:0] fill_reg;

    logic [ENTRIES-1:0]   hit_vec;
    logic [ENTRIES-1:0]   hit_sel;
    logic [ENTRIES-1:0]   free_vec;
    logic [ENTRIES-1:0]   free_sel;
    logic [ENTRIES-1:0]   lru_sel;
    logic [ENTRIES-1:0]   age_vec;
    logic [FILL_BITS-1:0] fill_dec;
    logic [RANK_BITS-1:0] last_rank;
    logic [RANK_BITS-1:0] hit_rank;
    logic [CMP_BITS-1:0]  cap_ext;
    logic [CMP_BITS-1:0]  cap_eff;
    logic [CMP_BITS-1:0]  fill_ext;
    logic                 any_hit;
    lttc_decision_t       dec;

    // Lowest matching valid entry and lowest free entry.
    assign hit_vec  = match_vec & valid_reg;
    assign hit_sel  = hit_vec & (~hit_vec + ENTRIES'(1));
    assign free_vec = ~valid_reg;
    assign free_sel = free_vec & (~free_vec + ENTRIES'(1));
    assign any_hit  = |hit_vec;

    // Valid ranks are a permutation of 0..fill-1, so the oldest holds fill-1.
    assign fill_dec  = fill_reg - FILL_BITS'(1);
    assign last_rank = fill_dec[RANK_BITS-1:0];

    always_comb
    begin
        hit_rank = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            lru_sel[i] = valid_reg[i] && (rank_reg[i] == last_rank);
            if (hit_sel[i])
            begin
                hit_rank = hit_rank | rank_reg[i];
            end
        end
    end

    // Clamp the configured capacity to 1..ENTRIES.
    assign cap_ext  = CMP_BITS'(capacity);
    assign fill_ext = CMP_BITS'(fill_reg);

    always_comb
    begin
        if (cap_ext == '0)
        begin
            cap_eff = CMP_BITS'(1);
        end
        else if (cap_ext > CMP_BITS'(ENTRIES))
        begin
            cap_eff = CMP_BITS'(ENTRIES);
        end
        else
        begin
            cap_eff = cap_ext;
        end
    end

    // Choose between hit, fill of a free entry and eviction of the oldest; a flush selects nothing.
    always_comb
    begin
        dec.hit   = any_hit;
        dec.fill  = !any_hit && (fill_ext < cap_eff);
        dec.evict = !any_hit && !(fill_ext < cap_eff);
        if (flush)
        begin
            dec      = '0;
            slot_sel = '0;
        end
        else if (dec.hit)
        begin
            slot_sel = hit_sel;
        end
        else if (dec.fill)
        begin
            slot_sel = free_sel;
        end
        else
        begin
            slot_sel = lru_sel;
        end
    end

    assign decision = dec;

    // Entries younger than the limit age by one; the chosen entry becomes newest.
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            age_vec[i] = valid_reg[i] && !slot_sel[i] &&
                         (!dec.hit || (rank_reg[i] < hit_rank));
        end
    end

    // Recency, valid and fill state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fill_reg  <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            if (flush)
            begin
                valid_reg <= '0;
                fill_reg  <= '0;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    rank_reg[i] <= '0;
                end
            end
            else
            begin
                valid_reg <= valid_reg | slot_sel;
                if (dec.fill)
                begin
                    fill_reg <= fill_reg + FILL_BITS'(1);
                end
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (slot_sel[i])
                    begin
                        rank_reg[i] <= '0;
                    end
                    else if (age_vec[i])
                    begin
                        rank_reg[i] <= rank_reg[i] + RANK_BITS'(1);
                    end
                end
            end
        end
    end

endmodule

>>> tb/tb_lru_tile_tag_cache_unit.sv
module tb_lru_tile_tag_cache_unit;
    import lttc_pkg::*;

    localparam int TILE_SLOTS = DEF_ENTRIES;
    localparam int CW         = DEF_COORD_BITS;
    localparam int COORD_MAX  = (1 << CW) - 1;

    typedef struct packed {
        op_t           op;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
    } tile_req_t;

    typedef struct packed {
        logic          hit;
        logic [3:0]    slot;
        logic          evicted;
        logic [CW-1:0] ex;
        logic [CW-1:0] ey;
    } tile_result_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic                operation = 1'b0;
    logic [CW-1:0]       tile_x    = '0;
    logic [CW-1:0]       tile_y    = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                hit;
    logic [3:0]          slot;
    logic                evicted;
    logic [CW-1:0]       evicted_x;
    logic [CW-1:0]       evicted_y;
    logic                cfg_write = 1'b0;
    logic [CAP_BITS-1:0] cfg_data  = '0;

    // Tag store as the testbench expects it to be.
    bit                  tag_valid [TILE_SLOTS];
    logic [CW-1:0]       tag_col   [TILE_SLOTS];
    logic [CW-1:0]       tag_row   [TILE_SLOTS];
    int                  tag_age   [TILE_SLOTS];
    int                  tag_fill;
    logic [CAP_BITS-1:0] tile_capacity = CAP_RESET;

    tile_req_t    tile_reqs[$];
    tile_result_t expected_results[$];

    logic [CW-1:0] pool_x [32];
    logic [CW-1:0] pool_y [32];
    int            pool_size = 1;

    int fail_count = 0;
    int words_in   = 0;
    int send_gap   = 0;
    int stall_gap  = 0;
    bit in_taken   = 1'b0;
    bit calm       = 1'b0;
    bit hold_off   = 1'b0;

    lru_tile_tag_cache_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .tile_x    (tile_x),
        .tile_y    (tile_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hit       (hit),
        .slot      (slot),
        .evicted   (evicted),
        .evicted_x (evicted_x),
        .evicted_y (evicted_y),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Empty the expected tag store.
    function automatic void clear_tags();
        for (int i = 0; i < TILE_SLOTS; i++)
        begin
            tag_valid[i] = 1'b0;
            tag_col[i]   = '0;
            tag_row[i]   = '0;
            tag_age[i]   = 0;
        end
        tag_fill = 0;
    endfunction

    // Apply one word to the expected tag store and return the result it causes.
    function automatic tile_result_t lookup_tile(op_t op, logic [CW-1:0] x,
                                                 logic [CW-1:0] y);
        tile_result_t res;
        int           cap_eff;
        int           pick;
        int           limit;
        int           top;
        bit           got;
        res  = '0;
        got  = 1'b0;
        pick = 0;
        top  = 0;
        if (op == OP_FLUSH)
        begin
            clear_tags();
            return res;
        end
        for (int i = 0; i < TILE_SLOTS; i++)
        begin
            if (!got && tag_valid[i] && tag_col[i] == x && tag_row[i] == y)
            begin
                pick = i;
                got  = 1'b1;
            end
        end
        cap_eff = (tile_capacity == 0) ? 1 :
                  (tile_capacity > TILE_SLOTS) ? TILE_SLOTS : int'(tile_capacity);
        if (got)
        begin
            res.hit = 1'b1;
            limit   = tag_age[pick];
        end
        else
        begin
            // Ranks never reach the slot count, so this ages every valid entry.
            limit = TILE_SLOTS;
            got   = 1'b0;
            if (tag_fill < cap_eff)
            begin
                for (int i = 0; i < TILE_SLOTS; i++)
                begin
                    if (!got && !tag_valid[i])
                    begin
                        pick = i;
                        got  = 1'b1;
                    end
                end
                tag_valid[pick] = 1'b1;
                tag_fill++;
            end
            else
            begin
                // Replace the least recent valid entry.
                for (int i = 0; i < TILE_SLOTS; i++)
                begin
                    if (tag_valid[i] && (!got || tag_age[i] > top))
                    begin
                        top  = tag_age[i];
                        pick = i;
                        got  = 1'b1;
                    end
                end
                res.evicted = 1'b1;
                res.ex      = tag_col[pick];
                res.ey      = tag_row[pick];
            end
            tag_col[pick] = x;
            tag_row[pick] = y;
        end
        for (int i = 0; i < TILE_SLOTS; i++)
        begin
            if (tag_valid[i] && i != pick && tag_age[i] < limit)
                tag_age[i]++;
        end
        tag_age[pick] = 0;
        res.slot      = pick[3:0];
        return res;
    endfunction

    // Gap length: mostly short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 93)
            return $urandom_range(3, 8);
        else
            return $urandom_range(15, 40);
    endfunction

    function automatic logic [CW-1:0] pick_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return COORD_MAX[CW-1:0];
        else
            return CW'($urandom_range(0, COORD_MAX));
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Monitor: checks result words, predicts accepted input words, tracks the register.
    always @(posedge clk)
    begin
        tile_result_t want;
        if (!rst_n)
        begin
            clear_tags();
            tile_capacity = CAP_RESET;
            in_taken <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                tile_capacity = cfg_data;
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word with no expectation pending");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("hit", want.hit, hit);
                    check_field("slot", want.slot, slot);
                    check_field("evicted", want.evicted, evicted);
                    check_field("evicted_x", want.ex, evicted_x);
                    check_field("evicted_y", want.ey, evicted_y);
                end
            end
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(lookup_tile(op_t'(operation), tile_x, tile_y));
                words_in++;
            end
        end
    end

    // Driver: presents queued words, holding each until it is taken.
    always @(negedge clk)
    begin
        tile_req_t req;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (tile_reqs.size() > 0)
            begin
                req = tile_reqs.pop_front();
                operation <= req.op;
                tile_x    <= req.x;
                tile_y    <= req.y;
                in_valid  <= 1'b1;
                send_gap  = (calm || $urandom_range(0, 2) != 0) ? 0 : gap_len();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus the long hold-off when requested.
    always @(negedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else if (stall_gap > 0)
        begin
            stall_gap--;
            out_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            stall_gap = gap_len() - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Long receiver hold-offs in the middle of busy phases, so the block backs up.
    initial
    begin
        int k;
        for (k = 0; k < 2; k++)
        begin
            do
                @(posedge clk);
            while (words_in < 120 + 180 * k || tile_reqs.size() < 20);
            hold_off = 1'b1;
            repeat (60) @(posedge clk);
            hold_off = 1'b0;
        end
    end

    task automatic add_req(op_t op, int x, int y);
        tile_reqs.push_back(tile_req_t'{op, CW'(x), CW'(y)});
    endtask

    // Wait until every queued word is taken and every result has come back.
    task automatic wait_drain();
        while (tile_reqs.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_BITS-1:0] value);
        @(negedge clk);
        cfg_data  <= value;
        cfg_write <= 1'b1;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // One phase: set the capacity while idle, then queue random words over a
    // small working set of tiles so that hits, fills and evictions all occur.
    task automatic run_phase(int cap, int set_size, int count, bit quiet);
        int r;
        int j;
        wait_drain();
        write_capacity(CAP_BITS'(cap));
        calm      = quiet;
        pool_size = set_size;
        for (j = 0; j < pool_size; j++)
        begin
            pool_x[j] = pick_coord();
            pool_y[j] = pick_coord();
        end
        for (j = 0; j < count; j++)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                add_req(OP_FLUSH, pick_coord(), pick_coord());
            else if (r < 15)
                add_req(OP_LOOKUP, pick_coord(), pick_coord());
            else
            begin
                r = $urandom_range(0, pool_size - 1);
                add_req(OP_LOOKUP, pool_x[r], pool_y[r]);
            end
        end
    endtask

    // Stimulus.
    initial
    begin
        int i;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed words at the reset capacity: coordinate extremes, a hit,
        // a flush with nonzero coordinates, a full store and evictions.
        add_req(OP_LOOKUP, 0, 0);
        add_req(OP_LOOKUP, COORD_MAX, COORD_MAX);
        add_req(OP_LOOKUP, COORD_MAX, 0);
        add_req(OP_LOOKUP, 0, COORD_MAX);
        add_req(OP_LOOKUP, 0, 0);
        add_req(OP_FLUSH, COORD_MAX, COORD_MAX);
        add_req(OP_LOOKUP, 0, 0);
        for (i = 1; i < TILE_SLOTS; i++)
            add_req(OP_LOOKUP, i * 273, COORD_MAX - i * 3);
        add_req(OP_LOOKUP, 0, 0);
        add_req(OP_LOOKUP, 2730, 1365);
        add_req(OP_LOOKUP, 273, COORD_MAX - 3);

        // Capacity sweep, including zero, values above the slot count, and a
        // drop below the current fill count without a flush.
        run_phase(1, 3, 40, 1'b0);
        run_phase(0, 3, 30, 1'b0);
        run_phase(31, 20, 50, 1'b1);
        run_phase(16, 20, 60, 1'b0);
        run_phase(4, 8, 50, 1'b0);
        run_phase(2, 4, 40, 1'b0);
        run_phase(8, 12, 50, 1'b0);
        run_phase(16, 24, 60, 1'b1);
        run_phase(5, 7, 40, 1'b0);

        wait_drain();
        calm = 1'b0;
        repeat (8) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #1000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
